// ===== sv/two_sensor_avoidance_steering_assert.svh =====
`ifndef TWO_SENSOR_AVOIDANCE_STEERING_ASSERT_SVH
`define TWO_SENSOR_AVOIDANCE_STEERING_ASSERT_SVH

// same-cycle implication
`define TSAS_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("tsas assertion failed");

// next-cycle implication
`define TSAS_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("tsas assertion failed");

`endif

// ===== sv/tsas_pkg.sv =====
package tsas_pkg;

    localparam int RANGE_W   = 12;
    localparam int YAW_W     = 16;
    localparam int RET_W     = 17;
    localparam int TURN_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 12;
    localparam int FULL_W    = 15;
    localparam int NUM_W     = FULL_W + RANGE_W;
    localparam int DIVD_W    = NUM_W + 1;
    localparam int DIVR_W    = RANGE_W + 1;
    localparam int DIV_STEPS = FULL_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_RUN_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIP_FRACTION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETURN_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AVOID_WEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_MAX      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_MIN      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_MAX     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_MIN     = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } tsas_state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic prep;
        logic div_step;
        logic out_load;
    } tsas_cmd_t;

    typedef struct packed {
        logic run_enable;
    } tsas_status_t;

endpackage

// ===== sv/two_sensor_avoidance_steering.sv =====
// Two-sensor obstacle avoidance steering. Each running transaction goes through
// the clamp and trip test, gain and span multiply, divider setup, 15 steps of
// the shared bit-serial divider for the rounded avoidance term, then the output
// load, which registers its result and raises m_tvalid.
// A new transaction is taken once the result sits in the output register,
// even while it waits for m_tready. With run_enable low, transactions are
// taken in one cycle each and dropped without a result.
module two_sensor_avoidance_steering
    import tsas_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,   // range_left_mm, range_right_mm, yaw_centideg
    input  logic                 s_tuser,   // rearm
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,   // return_term_centideg, turn_centideg
    output logic                 m_tuser    // obstacle
);

    tsas_cmd_t                cmd;
    tsas_status_t             status;
    logic signed [RET_W-1:0]  ret;
    logic signed [TURN_W-1:0] turn;

    tsas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tsas_dp u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .range_left_mm        (s_tdata[11:0]),
        .range_right_mm       (s_tdata[23:12]),
        .yaw_centideg         (s_tdata[39:24]),
        .rearm                (s_tuser),
        .cmd                  (cmd),
        .status               (status),
        .obstacle             (m_tuser),
        .return_term_centideg (ret),
        .turn_centideg        (turn)
    );

    assign m_tdata = {7'd0, turn, ret};

endmodule

// ===== sv/tsas_ctrl.sv =====
module tsas_ctrl
    import tsas_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  tsas_status_t status,
    output tsas_cmd_t    cmd
);

    tsas_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              accept;
    logic              div_last;

    assign accept   = s_tvalid && (state_reg == ST_IDLE);
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign div_last = (state_reg == ST_DIV) && (cnt_reg == CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && status.run_enable)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (div_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`include "two_sensor_avoidance_steering_assert.svh"

    `TSAS_ASSERT_NOW(a_out_load_free, cmd.out_load, !m_tvalid_reg || m_tready)
    `TSAS_ASSERT_NEXT(a_load_to_mul, accept && status.run_enable, state_reg == ST_MUL)
    `TSAS_ASSERT_NEXT(a_div_ends, div_last, state_reg == ST_FIN)
    `TSAS_ASSERT_NEXT(a_result_shown, cmd.out_load, m_tvalid_reg)

endmodule

// ===== sv/tsas_dp.sv =====
module tsas_dp
    import tsas_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_wdata,
    input  logic [RANGE_W-1:0]        range_left_mm,
    input  logic [RANGE_W-1:0]        range_right_mm,
    input  logic signed [YAW_W-1:0]   yaw_centideg,
    input  logic                      rearm,
    input  tsas_cmd_t                 cmd,
    output tsas_status_t              status,
    output logic                      obstacle,
    output logic signed [RET_W-1:0]   return_term_centideg,
    output logic signed [TURN_W-1:0]  turn_centideg
);

    // configuration
    logic               run_enable_reg;
    logic [7:0]         trip_fraction_reg;
    logic [7:0]         return_gain_reg;
    logic [7:0]         avoid_weight_reg;
    logic [RANGE_W-1:0] left_max_reg, left_min_reg, right_max_reg, right_min_reg;

    // state
    logic signed [YAW_W-1:0] start_heading_reg;
    logic                    latch_pending_reg;

    // working registers
    logic [RANGE_W-1:0]      lc_reg, rc_reg;
    logic                    tl_reg, tr_reg;
    logic signed [YAW_W:0]   diff_reg;
    logic [FULL_W-1:0]       full_reg;
    logic signed [17:0]      g_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [RANGE_W-1:0]      span_reg;
    logic                    sel_right_reg, zero_reg, full_case_reg;
    logic [DIVR_W-1:0]       div_reg;
    logic [DIVR_W-1:0]       rem_reg;
    logic [FULL_W-1:0]       q_reg;
    logic                    obstacle_reg;
    logic signed [RET_W-1:0] ret_reg;
    logic signed [TURN_W-1:0] turn_reg;

    assign status.run_enable   = run_enable_reg;
    assign obstacle            = obstacle_reg;
    assign return_term_centideg = ret_reg;
    assign turn_centideg       = turn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_enable_reg    <= 1'b1;
            trip_fraction_reg <= 8'd205;
            return_gain_reg   <= 8'd179;
            avoid_weight_reg  <= 8'd120;
            left_max_reg      <= 12'd900;
            left_min_reg      <= 12'd20;
            right_max_reg     <= 12'd900;
            right_min_reg     <= 12'd20;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RUN_ENABLE:    run_enable_reg    <= cfg_wdata[0];
                CFG_TRIP_FRACTION: trip_fraction_reg <= cfg_wdata[7:0];
                CFG_RETURN_GAIN:   return_gain_reg   <= cfg_wdata[7:0];
                CFG_AVOID_WEIGHT:  avoid_weight_reg  <= cfg_wdata[7:0];
                CFG_LEFT_MAX:      left_max_reg      <= cfg_wdata;
                CFG_LEFT_MIN:      left_min_reg      <= cfg_wdata;
                CFG_RIGHT_MAX:     right_max_reg     <= cfg_wdata;
                CFG_RIGHT_MIN:     right_min_reg     <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // accept stage
    logic [RANGE_W-1:0]      lc_next, rc_next;
    logic signed [YAW_W-1:0] start_next;
    logic [RANGE_W+7:0]      tl_lhs, tr_lhs, tl_rhs, tr_rhs;

    always_comb
    begin
        lc_next    = (range_left_mm < left_min_reg) ? left_min_reg : range_left_mm;
        rc_next    = (range_right_mm < right_min_reg) ? right_min_reg : range_right_mm;
        start_next = (rearm || latch_pending_reg) ? yaw_centideg : start_heading_reg;
        tl_lhs     = {lc_next, 8'd0};
        tr_lhs     = {rc_next, 8'd0};
        tl_rhs     = (RANGE_W+8)'(trip_fraction_reg) * (RANGE_W+8)'(left_max_reg);
        tr_rhs     = (RANGE_W+8)'(trip_fraction_reg) * (RANGE_W+8)'(right_max_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_heading_reg <= '0;
            latch_pending_reg <= 1'b1;
        end
        else if (cmd.load)
        begin
            start_heading_reg <= start_next;
            latch_pending_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lc_reg   <= lc_next;
            rc_reg   <= rc_next;
            tl_reg   <= tl_lhs < tl_rhs;
            tr_reg   <= tr_lhs < tr_rhs;
            diff_reg <= {yaw_centideg[YAW_W-1], yaw_centideg}
                        - {start_next[YAW_W-1], start_next};
            full_reg <= FULL_W'(avoid_weight_reg) * FULL_W'(7'd100);
        end
    end

    // multiply stage
    logic                    sel_right;
    logic [RANGE_W-1:0]      r_sel, mx_sel, mn_sel;
    logic signed [25:0]      g_prod, g_sum;

    always_comb
    begin
        sel_right = (tl_reg && tr_reg) ? (diff_reg > 0) : tr_reg;
        r_sel     = sel_right ? rc_reg : lc_reg;
        mx_sel    = sel_right ? right_max_reg : left_max_reg;
        mn_sel    = sel_right ? right_min_reg : left_min_reg;
        g_prod    = 26'($signed({1'b0, return_gain_reg})) * 26'(diff_reg);
        g_sum     = g_prod + 26'sd128;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            g_reg         <= g_sum[25:8];
            num_reg       <= NUM_W'(full_reg) * NUM_W'(mx_sel - r_sel);
            span_reg      <= mx_sel - mn_sel;
            sel_right_reg <= sel_right;
            zero_reg      <= r_sel >= mx_sel;
            full_case_reg <= mx_sel <= mn_sel;
        end
    end

    // rounding divider, one quotient bit per step
    logic [DIVD_W-1:0] dividend;
    logic [DIVR_W:0]   shifted;
    logic              q_bit;

    always_comb
    begin
        dividend = {num_reg, 1'b0} + DIVD_W'(span_reg);
        shifted  = {rem_reg, q_reg[FULL_W-1]};
        q_bit    = shifted >= {1'b0, div_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            div_reg <= {span_reg, 1'b0};
            rem_reg <= dividend[DIVD_W-1:FULL_W];
            q_reg   <= dividend[FULL_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= q_bit ? DIVR_W'(shifted - {1'b0, div_reg}) : shifted[DIVR_W-1:0];
            q_reg   <= {q_reg[FULL_W-2:0], q_bit};
        end
    end

    // final stage
    logic [FULL_W-1:0]  a_val;
    logic signed [18:0] a_ext, t_raw, t_wrap, t_sat;
    logic signed [17:0] neg_g;

    always_comb
    begin
        a_val = full_case_reg ? full_reg : (zero_reg ? '0 : q_reg);
        a_ext = $signed({4'b0, a_val});
        neg_g = -g_reg;
        if (tl_reg || tr_reg)
        begin
            t_raw = sel_right_reg ? a_ext : -a_ext;
        end
        else
        begin
            t_raw = {neg_g[17], neg_g};
        end
        if (t_raw > 19'sd18000)
        begin
            t_wrap = t_raw - 19'sd36000;
        end
        else if (t_raw < -19'sd18000)
        begin
            t_wrap = t_raw + 19'sd36000;
        end
        else
        begin
            t_wrap = t_raw;
        end
        if (t_wrap > 19'sd18000)
        begin
            t_sat = 19'sd18000;
        end
        else if (t_wrap < -19'sd18000)
        begin
            t_sat = -19'sd18000;
        end
        else
        begin
            t_sat = t_wrap;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            obstacle_reg <= tl_reg || tr_reg;
            ret_reg      <= neg_g[RET_W-1:0];
            turn_reg     <= t_sat[TURN_W-1:0];
        end
    end

endmodule
